@@ rtl/hcs_pkg.sv @@
package hcs_pkg;

	localparam int LETTER_W = 5;
	localparam int KEY_W = 5;
	localparam int CHAR_W = 7;
	localparam int SUM_W = 11;
	localparam int QUOT_W = 6;

	localparam logic [LETTER_W-1:0] PAD_VALUE = 5'd23;
	localparam logic [SUM_W-1:0] LETTER_COUNT = 11'd26;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;

	// floor(s / 26) == (s * 2521) >> 16 for every sum up to 2 * 31 * 25.
	localparam int RECIP_W = 12;
	localparam logic [RECIP_W-1:0] RECIP_MULT = 12'd2521;
	localparam int RECIP_SHIFT = 16;
	localparam int RPROD_W = SUM_W + RECIP_W;

	localparam int QUEUE_DEPTH = 2;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_K00 = 2'd0;
	localparam logic [1:0] REG_K01 = 2'd1;
	localparam logic [1:0] REG_K10 = 2'd2;
	localparam logic [1:0] REG_K11 = 2'd3;

	localparam logic [KEY_W-1:0] K00_RESET = 5'd9;
	localparam logic [KEY_W-1:0] K01_RESET = 5'd4;
	localparam logic [KEY_W-1:0] K10_RESET = 5'd5;
	localparam logic [KEY_W-1:0] K11_RESET = 5'd7;

	typedef logic [LETTER_W-1:0] letter_t;

	typedef struct packed {
		letter_t p0;
		letter_t p1;
	} pair_t;

	typedef struct packed {
		logic [KEY_W-1:0] k00;
		logic [KEY_W-1:0] k01;
		logic [KEY_W-1:0] k10;
		logic [KEY_W-1:0] k11;
	} key_t;

endpackage

@@ rtl/hill_cipher_2x2_stream_encrypt.sv @@
// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready        in_char, end_of_message
// out       output     out_valid / out_ready      cipher_char, last_of_run
// config    input      APB write / read           key_row0_col0 .. key_row1_col1
//
// A byte is taken each cycle while the pair queue has room; a pair leaves as two words,
// the first word and then the one flagged last_of_run, and a letter stream sustains one
// byte per cycle while out_ready stays high. The completing byte passes through the queue,
// the product sums, the quotient and the result register before the first word is valid.
// Reset clears the held letter, the queue and the pipeline and loads the default key.
// The pair queue lets the input side keep going while the output side stalls.
module hill_cipher_2x2_stream_encrypt #(
	parameter int QUEUE_DEPTH = hcs_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 in_char,
	input  logic                       end_of_message,
	input  logic                       in_valid,
	output logic                       in_ready,
	output logic [6:0]                 cipher_char,
	output logic                       last_of_run,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hcs_pkg::ADDR_W-1:0] paddr,
	input  logic [hcs_pkg::DATA_W-1:0] pwdata,
	output logic [hcs_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import hcs_pkg::*;

	key_t       key_q;
	logic       cfg_write;
	logic [1:0] reg_index;
	logic       push_valid;
	logic       push_ready;
	pair_t      push_pair;
	logic       pop_valid;
	logic       pop_ready;
	pair_t      pop_pair;

	assign pready = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign reg_index = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.k00 <= K00_RESET;
			key_q.k01 <= K01_RESET;
			key_q.k10 <= K10_RESET;
			key_q.k11 <= K11_RESET;
		end else if (cfg_write) begin
			case (reg_index)
				REG_K00: key_q.k00 <= pwdata[KEY_W-1:0];
				REG_K01: key_q.k01 <= pwdata[KEY_W-1:0];
				REG_K10: key_q.k10 <= pwdata[KEY_W-1:0];
				REG_K11: key_q.k11 <= pwdata[KEY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_K00: prdata = DATA_W'(key_q.k00);
			REG_K01: prdata = DATA_W'(key_q.k01);
			REG_K10: prdata = DATA_W'(key_q.k10);
			REG_K11: prdata = DATA_W'(key_q.k11);
			default: prdata = '0;
		endcase
	end

	hcs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_char       (in_char),
		.end_of_message(end_of_message),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.push_valid    (push_valid),
		.push_pair     (push_pair),
		.push_ready    (push_ready)
	);

	hcs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_pair (push_pair),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_pair  (pop_pair),
		.pop_ready (pop_ready)
	);

	hcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        (key_q),
		.pop_valid  (pop_valid),
		.pop_pair   (pop_pair),
		.pop_ready  (pop_ready),
		.cipher_char(cipher_char),
		.last_of_run(last_of_run),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

@@ rtl/hcs_front.sv @@
module hcs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     in_char,
	input  logic           end_of_message,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           push_valid,
	output hcs_pkg::pair_t push_pair,
	input  logic           push_ready
);
	import hcs_pkg::*;

	letter_t held_letter_q;
	logic    have_held_q;
	logic    accept;
	logic    is_upper;
	logic    is_lower;
	logic    is_letter;
	letter_t letter;
	letter_t held_d;
	logic    have_d;

	assign in_ready = push_ready;
	assign accept = in_valid & in_ready;

	assign is_upper = (in_char >= 8'd65) && (in_char <= 8'd90);
	assign is_lower = (in_char >= 8'd97) && (in_char <= 8'd122);
	assign is_letter = is_upper | is_lower;
	// Both cases have 'A' or 'a' at 1 in the low five bits.
	assign letter = in_char[4:0] - 5'd1;

	always_comb begin
		push_valid = 1'b0;
		push_pair.p0 = held_letter_q;
		push_pair.p1 = PAD_VALUE;
		held_d = held_letter_q;
		have_d = have_held_q;
		if (is_letter && have_held_q) begin
			push_valid = accept;
			push_pair.p1 = letter;
			have_d = 1'b0;
		end else if (is_letter) begin
			held_d = letter;
			push_pair.p0 = letter;
			if (end_of_message) begin
				push_valid = accept;
			end else begin
				have_d = 1'b1;
			end
		end else if (end_of_message && have_held_q) begin
			push_valid = accept;
			have_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			have_held_q <= 1'b0;
		end else if (accept) begin
			held_letter_q <= held_d;
			have_held_q <= have_d;
		end
	end

endmodule

@@ rtl/hcs_queue.sv @@
module hcs_queue #(
	parameter int DEPTH = hcs_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  hcs_pkg::pair_t push_pair,
	output logic           push_ready,
	output logic           pop_valid,
	output hcs_pkg::pair_t pop_pair,
	input  logic           pop_ready
);
	import hcs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	pair_t            slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid = (count_q != '0);
	assign pop_pair = slots_q[rd_ptr_q];
	assign do_push = push_valid & push_ready;
	assign do_pop = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/hcs_back.sv @@
module hcs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  hcs_pkg::key_t  key,
	input  logic           pop_valid,
	input  hcs_pkg::pair_t pop_pair,
	output logic           pop_ready,
	output logic [6:0]     cipher_char,
	output logic           last_of_run,
	output logic           out_valid,
	input  logic           out_ready
);
	import hcs_pkg::*;

	logic [SUM_W-1:0]   sum0_s1, sum1_s1;
	logic               valid_s1;
	logic [SUM_W-1:0]   sum0_s2, sum1_s2;
	logic [QUOT_W-1:0]  quot0_s2, quot1_s2;
	logic               valid_s2;
	logic [CHAR_W-1:0]  char0_s3, char1_s3;
	logic               valid_s3;
	logic               second_q;

	logic               take;
	logic               load_s3;
	logic               adv_s2;
	logic               adv_s1;
	logic [SUM_W-1:0]   sum0_d, sum1_d;
	logic [RPROD_W-1:0] rprod0, rprod1;
	logic [SUM_W-1:0]   rem0, rem1;

	assign out_valid = valid_s3;
	assign cipher_char = second_q ? char1_s3 : char0_s3;
	assign last_of_run = second_q;
	assign take = out_valid & out_ready;

	// The result register frees up as the second word of its pair leaves.
	assign load_s3 = valid_s2 && (!valid_s3 || (take && second_q));
	assign adv_s2 = !valid_s2 || load_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop_ready = adv_s1;

	always_comb begin
		sum0_d = SUM_W'(key.k00 * pop_pair.p0) + SUM_W'(key.k01 * pop_pair.p1);
		sum1_d = SUM_W'(key.k10 * pop_pair.p0) + SUM_W'(key.k11 * pop_pair.p1);
		rprod0 = RPROD_W'(sum0_s1) * RPROD_W'(RECIP_MULT);
		rprod1 = RPROD_W'(sum1_s1) * RPROD_W'(RECIP_MULT);
		rem0 = sum0_s2 - SUM_W'(quot0_s2) * LETTER_COUNT;
		rem1 = sum1_s2 - SUM_W'(quot1_s2) * LETTER_COUNT;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pop_valid) begin
			sum0_s1 <= sum0_d;
			sum1_s1 <= sum1_d;
		end
		if (adv_s2 && valid_s1) begin
			sum0_s2 <= sum0_s1;
			sum1_s2 <= sum1_s1;
			quot0_s2 <= rprod0[RECIP_SHIFT +: QUOT_W];
			quot1_s2 <= rprod1[RECIP_SHIFT +: QUOT_W];
		end
		if (load_s3) begin
			char0_s3 <= ASCII_UPPER_A + CHAR_W'(rem0[LETTER_W-1:0]);
			char1_s3 <= ASCII_UPPER_A + CHAR_W'(rem1[LETTER_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_s3) begin
				valid_s3 <= 1'b1;
			end else if (take && second_q) begin
				valid_s3 <= 1'b0;
			end
			if (take) begin
				second_q <= !second_q;
			end
		end
	end

endmodule

@@ tb/cipher_checker.sv @@
`timescale 1ns / 1ps

module cipher_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 in_char,
	input  logic                       end_of_message,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [6:0]                 cipher_char,
	input  logic                       last_of_run,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [hcs_pkg::ADDR_W-1:0] paddr,
	input  logic [hcs_pkg::DATA_W-1:0] pwdata,
	output int                         mismatches,
	output int                         words_due
);
	import hcs_pkg::*;

	localparam int ALPHABET = 26;
	localparam letter_t FILLER_LETTER = 5'd23;
	localparam logic [7:0] UPPER_FIRST = 8'h41;
	localparam logic [7:0] UPPER_LAST = 8'h5A;
	localparam logic [7:0] LOWER_FIRST = 8'h61;
	localparam logic [7:0] LOWER_LAST = 8'h7A;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} cipher_word_t;

	cipher_word_t cipher_words_due[$];
	cipher_word_t want;
	key_t key;
	letter_t held;
	logic held_valid;
	int fail_count = 0;

	function automatic logic [6:0] encrypt_letter(input logic [KEY_W-1:0] ka,
			input logic [KEY_W-1:0] kb, input letter_t p0, input letter_t p1);
		int unsigned total;
		total = int'(ka) * int'(p0) + int'(kb) * int'(p1);
		return 7'(int'(UPPER_FIRST) + total % ALPHABET);
	endfunction

	task automatic queue_pair(input letter_t p0, input letter_t p1);
		cipher_word_t w;
		w.ch = encrypt_letter(key.k00, key.k01, p0, p1);
		w.last = 1'b0;
		cipher_words_due.push_back(w);
		w.ch = encrypt_letter(key.k10, key.k11, p0, p1);
		w.last = 1'b1;
		cipher_words_due.push_back(w);
	endtask

	task automatic predict_byte(input logic [7:0] value, input logic eom);
		letter_t v;
		logic is_letter;
		is_letter = 1'b1;
		v = '0;
		if (value >= UPPER_FIRST && value <= UPPER_LAST) begin
			v = letter_t'(value - UPPER_FIRST);
		end else if (value >= LOWER_FIRST && value <= LOWER_LAST) begin
			v = letter_t'(value - LOWER_FIRST);
		end else begin
			is_letter = 1'b0;
		end
		// A letter that completes a pair ends the byte; the end flag pads only a held letter.
		if (is_letter && held_valid) begin
			held_valid = 1'b0;
			queue_pair(held, v);
		end else begin
			if (is_letter) begin
				held = v;
				held_valid = 1'b1;
			end
			if (eom && held_valid) begin
				held_valid = 1'b0;
				queue_pair(held, FILLER_LETTER);
			end
		end
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key = '{k00: K00_RESET, k01: K01_RESET, k10: K10_RESET, k11: K11_RESET};
			held = '0;
			held_valid = 1'b0;
			cipher_words_due.delete();
			fail_count = 0;
			mismatches <= 0;
			words_due <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_K00: key.k00 = pwdata[KEY_W-1:0];
					REG_K01: key.k01 = pwdata[KEY_W-1:0];
					REG_K10: key.k10 = pwdata[KEY_W-1:0];
					REG_K11: key.k11 = pwdata[KEY_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_byte(in_char, end_of_message);
			if (out_valid && out_ready) begin
				if (cipher_words_due.size() == 0) begin
					note_failure($sformatf("unexpected word: char %0d last %0b",
						cipher_char, last_of_run));
				end else begin
					want = cipher_words_due.pop_front();
					if (cipher_char !== want.ch || last_of_run !== want.last)
						note_failure($sformatf(
							"word mismatch: expected char %0d last %0b, got char %0d last %0b",
							want.ch, want.last, cipher_char, last_of_run));
				end
			end
			mismatches <= fail_count;
			words_due <= cipher_words_due.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import hcs_pkg::*;

	localparam int QUIET_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int PHASES = 5;
	localparam logic [7:0] UPPER_FIRST = 8'h41;
	localparam logic [7:0] LOWER_FIRST = 8'h61;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [7:0] in_char = '0;
	logic end_of_message = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [6:0] cipher_char;
	logic last_of_run;
	logic out_valid;
	logic out_ready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	int mismatches;
	int words_due;
	int bytes_sent = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;

	hill_cipher_2x2_stream_encrypt u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_char(in_char),
		.end_of_message(end_of_message),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cipher_char(cipher_char),
		.last_of_run(last_of_run),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cipher_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_char(in_char),
		.end_of_message(end_of_message),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cipher_char(cipher_char),
		.last_of_run(last_of_run),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.words_due(words_due)
	);

	always #5 clk = ~clk;

	// The long hold-off lets the pair queue fill so that the input side must stall.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] value, input logic eom);
		in_valid <= 1'b1;
		in_char <= value;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			in_char <= 8'($urandom);
			end_of_message <= 1'($urandom);
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(input logic [1:0] idx, input logic [KEY_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {(DATA_W-KEY_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 8'(UPPER_FIRST + $urandom_range(25));
			5, 6: return 8'(LOWER_FIRST + $urandom_range(25));
			7: return 8'($urandom_range(255));
			default: begin
				// Bytes just outside the letter ranges and the ends of the byte range.
				case ($urandom_range(5))
					0: return 8'h40;
					1: return 8'h5B;
					2: return 8'h60;
					3: return 8'h7B;
					4: return 8'h00;
					default: return 8'hFF;
				endcase
			end
		endcase
	endfunction

	task automatic send_message();
		int len;
		logic noisy;
		len = $urandom_range(1, 12);
		noisy = ($urandom_range(9) == 0);
		for (int i = 0; i < len; i++) begin
			if (noisy)
				push_byte(8'($urandom), 1'($urandom));
			else
				push_byte(pick_byte(), i == len - 1);
		end
	endtask

	initial begin
		key_t key_set;
		int target;
		logic paused;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Letter extremes in both cases, with non-letters between the halves of a pair.
		push_byte("A", 1'b0);
		push_byte("Z", 1'b0);
		push_byte("a", 1'b0);
		push_byte("z", 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte("b", 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h40, 1'b0);
		push_byte(8'h5B, 1'b0);
		push_byte(8'h60, 1'b0);
		push_byte(8'h7B, 1'b0);
		push_byte(8'hC1, 1'b0);
		push_byte(8'hE1, 1'b0);
		push_byte("y", 1'b0);
		// An odd letter carrying the end flag is padded.
		push_byte("q", 1'b1);
		// The end flag on a dropped byte still pads the held letter.
		push_byte("m", 1'b0);
		push_byte(8'h20, 1'b1);
		// The end flag with nothing held does nothing.
		push_byte(8'h37, 1'b1);
		// The end flag on the completing letter adds no padding.
		push_byte("h", 1'b0);
		push_byte("i", 1'b1);
		// Leave a letter held, to be paired with the first letter sent in phase 0.
		push_byte("k", 1'b0);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: key_set = '{k00: 5'd0, k01: 5'd0, k10: 5'd0, k11: 5'd0};
				2: key_set = '{k00: 5'd31, k01: 5'd30, k10: 5'd26, k11: 5'd31};
				3: key_set = '{k00: 5'd25, k01: 5'd25, k10: 5'd25, k11: 5'd25};
				default: key_set = '{k00: 5'($urandom_range(31)), k01: 5'($urandom_range(31)),
					k10: 5'($urandom_range(31)), k11: 5'($urandom_range(31))};
			endcase
			if (phase != 0) begin
				write_key(REG_K00, key_set.k00);
				write_key(REG_K01, key_set.k01);
				write_key(REG_K10, key_set.k10);
				write_key(REG_K11, key_set.k11);
			end
			case (phase)
				0: begin
					send_gap_pct = 0;
					stall_pct <= 0;
					hold_req <= 1'b1;
				end
				1: begin
					send_gap_pct = 57;
					stall_pct <= 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct <= 57;
				end
				3: begin
					send_gap_pct = 6;
					stall_pct <= 6;
				end
				default: begin
					send_gap_pct = 0;
					stall_pct <= 0;
				end
			endcase
			target = bytes_sent + ITEMS_PER_PHASE;
			while (bytes_sent < target) begin
				if (phase == 2 && !paused && bytes_sent >= target - ITEMS_PER_PHASE / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				send_message();
			end
			wait_drained();
		end

		if (mismatches == 0 && words_due == 0)
			$display("[hill_cipher_2x2_stream_encrypt] OK");
		else
			$display("[hill_cipher_2x2_stream_encrypt] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[hill_cipher_2x2_stream_encrypt] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/hcs_pkg.sv
rtl/hcs_front.sv
rtl/hcs_queue.sv
rtl/hcs_back.sv
rtl/hill_cipher_2x2_stream_encrypt.sv
tb/cipher_checker.sv
tb/testbench.sv
